// ===== design/deq_pkg.sv =====
// shared types and codes for the double-ended queue core
package deq_pkg;

	// requested operation
	typedef enum logic [2:0] {
		FN_PUSH_HEAD = 3'd0,
		FN_PUSH_TAIL = 3'd1,
		FN_POP_HEAD  = 3'd2,
		FN_POP_TAIL  = 3'd3,
		FN_PEEK_HEAD = 3'd4,
		FN_PEEK_TAIL = 3'd5,
		FN_CONTAINS  = 3'd6,
		FN_REMOVE    = 3'd7
	} func_t;

	// result status
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// action applied by every cell of the row in the same cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SCAN_INIT,
		CELL_SCAN_STEP,
		CELL_PUSH_HEAD,
		CELL_PUSH_TAIL,
		CELL_POP_HEAD,
		CELL_REMOVE
	} cell_op_t;

	localparam int DATA_W = 32;

	// broadcast control for the cell row
	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

	// operations that need the prefix scan over the row
	function automatic logic needs_scan(input func_t f);
		return f inside {FN_POP_TAIL, FN_PEEK_TAIL, FN_CONTAINS, FN_REMOVE};
	endfunction

endpackage

// ===== design/deq_cell.sv =====
// one storage cell of the queue row with its scan registers
module deq_cell import deq_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int IDX = 0,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic [CntW-1:0]     count,
	input  logic [DATA_W-1:0]   left_data,
	input  logic [DATA_W-1:0]   right_data,
	input  logic [DATA_W-1:0]   partner_red,
	input  logic                partner_hit,
	output logic [DATA_W-1:0]   data,
	output logic [DATA_W-1:0]   red,
	output logic                hit
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] red_q;
	logic              hit_q;
	logic              occupied;
	logic              is_tail;
	logic              is_next;

	// position of this cell against the fill level
	assign occupied = CntW'(IDX) < count;
	assign is_tail  = count == CntW'(IDX + 1);
	assign is_next  = count == CntW'(IDX);

	// entry storage and shifting between neighbors
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH_HEAD: data_q <= left_data;
			CELL_PUSH_TAIL: begin
				if (is_next) begin
					data_q <= ctrl.value;
				end
			end
			CELL_POP_HEAD: data_q <= right_data;
			CELL_REMOVE: begin
				if (hit_q) begin
					data_q <= right_data;
				end
			end
			default: ;
		endcase
	end

	// prefix-or scan: match flag and tail value
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_SCAN_INIT: begin
				hit_q <= occupied && (data_q == ctrl.value);
				red_q <= is_tail ? data_q : '0;
			end
			CELL_SCAN_STEP: begin
				hit_q <= hit_q | partner_hit;
				red_q <= red_q | partner_red;
			end
			default: ;
		endcase
	end

	assign data = data_q;
	assign red  = red_q;
	assign hit  = hit_q;

endmodule

// ===== design/double_ended_queue_core.sv =====
// top level of the double-ended queue: controller and cell row
//
// Bounded double-ended queue of signed 32-bit values, up to DEPTH entries, held
// in a row of cells with the head in cell 0. One request is worked at a time.
// Push head, push tail, pop head and peek head go from S_IDLE to S_FINISH, where
// the result is registered once the output register is free; pop tail, peek tail,
// contains and remove pass through S_SCAN first, the prefix-or scan through the
// cell row, which doubles its stride at each step to find the first match and the
// tail entry. A new request is taken once the result sits in the output
// register, even while that result waits. Storage needs no clearing after reset.
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]         status,
	output logic               found,
	output logic [6:0]         count
);

	localparam int CntW = $clog2(DEPTH + 1);
	localparam int L    = $clog2(DEPTH);
	localparam int LvlW = (L > 1) ? $clog2(L) : 1;
	localparam int NLvl = 2 ** LvlW;

	state_t            state_q, state_nxt;
	func_t             func_q;
	logic [DATA_W-1:0] value_q;
	logic [LvlW-1:0]   lvl_q;
	logic [CntW-1:0]   count_q;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] result_value_q;
	status_t           status_q;
	logic              found_q;
	logic [6:0]        count_out_q;

	logic              req_fire;
	logic              out_free;
	logic              apply;
	cell_ctrl_t        ctrl;

	logic [DATA_W-1:0] res_value;
	status_t           res_status;
	logic              res_found;
	logic [CntW-1:0]   count_nxt;
	cell_op_t          finish_op;
	logic [CntW+6:0]   count_ext;

	logic [DEPTH-1:0][DATA_W-1:0] cell_data;
	logic [DEPTH-1:0][DATA_W-1:0] cell_red;
	logic [DEPTH-1:0]             cell_hit;
	logic [DEPTH-1:0][DATA_W-1:0] left_data;
	logic [DEPTH-1:0][DATA_W-1:0] right_data;
	logic [DEPTH-1:0][DATA_W-1:0] partner_red;
	logic [DEPTH-1:0]             partner_hit;
	logic [DEPTH-1:0][NLvl-1:0][DATA_W:0] cand;

	logic              empty;
	logic              full;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign apply     = (state_q == S_FINISH) && out_free;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CntW'(DEPTH));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_nxt = needs_scan(func_t'(func)) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (lvl_q == LvlW'(L - 1)) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// result and row action for the finishing request
	always_comb begin
		res_value  = '0;
		res_status = STAT_OK;
		res_found  = 1'b0;
		count_nxt  = count_q;
		finish_op  = CELL_HOLD;
		case (func_q)
			FN_PUSH_HEAD, FN_PUSH_TAIL: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					count_nxt = count_q + CntW'(1);
					finish_op = (func_q == FN_PUSH_HEAD) ? CELL_PUSH_HEAD : CELL_PUSH_TAIL;
				end
			end
			FN_POP_HEAD: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = cell_data[0];
					count_nxt = count_q - CntW'(1);
					finish_op = CELL_POP_HEAD;
				end
			end
			FN_POP_TAIL: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = cell_red[DEPTH-1];
					count_nxt = count_q - CntW'(1);
				end
			end
			FN_PEEK_HEAD: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = cell_data[0];
				end
			end
			FN_PEEK_TAIL: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = cell_red[DEPTH-1];
				end
			end
			FN_CONTAINS: res_found = cell_hit[DEPTH-1];
			FN_REMOVE: begin
				if (cell_hit[DEPTH-1]) begin
					res_found = 1'b1;
					count_nxt = count_q - CntW'(1);
					finish_op = CELL_REMOVE;
				end
			end
			default: ;
		endcase
	end

	// broadcast control to the row
	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.value = value_q;
		case (state_q)
			S_IDLE: begin
				ctrl.value = value;
				if (req_fire) begin
					ctrl.op = CELL_SCAN_INIT;
				end
			end
			S_SCAN: ctrl.op = CELL_SCAN_STEP;
			S_FINISH: begin
				if (apply) begin
					ctrl.op = finish_op;
				end
			end
			default: ;
		endcase
	end

	assign count_ext = {7'd0, count_nxt};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lvl_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_SCAN) begin
				lvl_q <= lvl_q + LvlW'(1);
			end else begin
				lvl_q <= '0;
			end
			if (apply) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			func_q  <= func_t'(func);
			value_q <= value;
		end
		if (apply) begin
			result_value_q <= res_value;
			status_q       <= res_status;
			found_q        <= res_found;
			count_out_q    <= count_ext[6:0];
		end
	end

	// neighbor and scan-partner wiring of the cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		if (i == 0) begin : g_first
			assign left_data[i] = ctrl.value;
		end else begin : g_mid
			assign left_data[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data[i] = cell_data[i];
		end else begin : g_inner
			assign right_data[i] = cell_data[i+1];
		end

		for (genvar k = 0; k < NLvl; k++) begin : g_lvl
			if (k < L && i >= (1 << k)) begin : g_take
				assign cand[i][k] = {cell_hit[i-(1<<k)], cell_red[i-(1<<k)]};
			end else begin : g_zero
				assign cand[i][k] = '0;
			end
		end
		assign {partner_hit[i], partner_red[i]} = cand[i][lvl_q];

		deq_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_data   (left_data[i]),
			.right_data  (right_data[i]),
			.partner_red (partner_red[i]),
			.partner_hit (partner_hit[i]),
			.data        (cell_data[i]),
			.red         (cell_red[i]),
			.hit         (cell_hit[i])
		);
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign found        = found_q;
	assign count        = count_out_q;

endmodule

// ===== tb/deque_monitor.sv =====
// channel monitor for the double-ended queue: predicts each result and compares it
module deque_monitor import deq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic signed [31:0] result_value,
	input  logic [1:0]         status,
	input  logic               found,
	input  logic [6:0]         count,
	output int                 errors,
	output int                 awaited,
	output int                 checked,
	output int                 full_hits,
	output int                 empty_hits,
	output int                 found_hits
);

	// one predicted result
	typedef struct {
		logic signed [31:0] rv;
		status_t            st;
		logic               fnd;
		logic [6:0]         cnt;
	} deq_result_t;

	// mirror of the queue contents, head at index 0
	logic signed [31:0] held[$];
	// results predicted but not yet seen on the response channel
	deq_result_t awaited_results[$];
	deq_result_t want;

	int err_total = 0;
	int awaited_total = 0;
	int checked_total = 0;
	int full_total = 0;
	int empty_total = 0;
	int found_total = 0;

	assign errors     = err_total;
	assign awaited    = awaited_total;
	assign checked    = checked_total;
	assign full_hits  = full_total;
	assign empty_hits = empty_total;
	assign found_hits = found_total;

	// apply one request to the mirror and return what the block should answer
	function automatic deq_result_t deque_apply(func_t f, logic signed [31:0] v);
		deq_result_t r;
		int idx;
		int i;
		r.rv = '0;
		r.st = STAT_OK;
		r.fnd = 1'b0;
		idx = -1;
		case (f)
			FN_PUSH_HEAD: begin
				if (held.size() >= DEPTH) r.st = STAT_FULL;
				else held.push_front(v);
			end
			FN_PUSH_TAIL: begin
				if (held.size() >= DEPTH) r.st = STAT_FULL;
				else held.push_back(v);
			end
			FN_POP_HEAD: begin
				if (held.size() == 0) r.st = STAT_EMPTY;
				else r.rv = held.pop_front();
			end
			FN_POP_TAIL: begin
				if (held.size() == 0) r.st = STAT_EMPTY;
				else r.rv = held.pop_back();
			end
			FN_PEEK_HEAD: begin
				if (held.size() == 0) r.st = STAT_EMPTY;
				else r.rv = held[0];
			end
			FN_PEEK_TAIL: begin
				if (held.size() == 0) r.st = STAT_EMPTY;
				else r.rv = held[held.size() - 1];
			end
			default: begin
				// first match counted from the head
				for (i = 0; i < held.size() && idx < 0; i++)
					if (held[i] == v) idx = i;
				r.fnd = (idx >= 0);
				if (f == FN_REMOVE && idx >= 0) held.delete(idx);
			end
		endcase
		r.cnt = 7'(held.size());
		return r;
	endfunction

	// print one line per mismatch and count it
	task automatic report(string what, longint got, longint exp_val);
		$display("%0t error: %s got %0d, predicted %0d", $time, what, got, exp_val);
		err_total++;
	endtask

	// compare each response transaction, then predict for each request transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held.delete();
			awaited_results.delete();
			awaited_total = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					report("response with nothing outstanding, count", count, 0);
				end else begin
					want = awaited_results.pop_front();
					if (result_value !== want.rv) report("result_value", result_value, want.rv);
					if (status !== want.st) report("status", status, want.st);
					if (found !== want.fnd) report("found", found, want.fnd);
					if (count !== want.cnt) report("count", count, want.cnt);
					checked_total++;
					if (want.st == STAT_FULL) full_total++;
					if (want.st == STAT_EMPTY) empty_total++;
					if (want.fnd) found_total++;
				end
			end
			if (req_valid && req_ready)
				awaited_results.push_back(deque_apply(func_t'(func), value));
			awaited_total = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// testbench top for the double-ended queue: stimulus, idling and verdict
module tb;
	import deq_pkg::*;

	localparam int DEPTH     = 64;
	localparam int ITEMS     = 750;
	localparam int CALM_FROM = 650;

	// operation mix of one random segment
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic               rsp_valid;
	logic               rsp_ready;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic               found;
	logic [6:0]         count;

	int errors;
	int awaited;
	int checked;
	int full_hits;
	int empty_hits;
	int found_hits;
	int sent = 0;
	bit calm = 1'b0;

	// clock, period 12
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	double_ended_queue_core #(.DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.result_value(result_value),
		.status(status),
		.found(found),
		.count(count)
	);

	deque_monitor #(.DEPTH(DEPTH)) i_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.result_value(result_value),
		.status(status),
		.found(found),
		.count(count),
		.errors(errors),
		.awaited(awaited),
		.checked(checked),
		.full_hits(full_hits),
		.empty_hits(empty_hits),
		.found_hits(found_hits)
	);

	// present one request and hold it until the transaction completes
	task automatic send(func_t f, logic signed [31:0] v);
		req_valid <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	// random gap on the request side
	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// mostly a small pool so contains and remove hit, sometimes any 32-bit value
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return -int'($urandom_range(1, 8));
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	function automatic func_t pick_func(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (mix == MIX_FILL && r < 70)
			return $urandom_range(0, 1) ? FN_PUSH_TAIL : FN_PUSH_HEAD;
		if (mix == MIX_DRAIN && r < 65) begin
			case ($urandom_range(0, 2))
				0: return FN_POP_HEAD;
				1: return FN_POP_TAIL;
				default: return FN_REMOVE;
			endcase
		end
		return func_t'($urandom_range(0, 7));
	endfunction

	// response side stalls in bursts, always ready near the end
	initial begin
		rsp_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (calm) begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// main stimulus and verdict
	initial begin
		mix_t mix;
		int seg_len;
		int k;
		req_valid <= 1'b0;
		func <= FN_PUSH_HEAD;
		value <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every pop and peek on empty, search on empty
		send(FN_POP_HEAD, 32'sd0);      maybe_gap();
		send(FN_POP_TAIL, -32'sd1);     maybe_gap();
		send(FN_PEEK_HEAD, 32'sd0);     maybe_gap();
		send(FN_PEEK_TAIL, 32'sd0);     maybe_gap();
		send(FN_CONTAINS, 32'sd0);      maybe_gap();
		send(FN_REMOVE, 32'sd0);        maybe_gap();
		// pop tail on a single entry empties the queue
		send(FN_PUSH_TAIL, 32'sh7fffffff); maybe_gap();
		send(FN_POP_TAIL, 32'sd0);      maybe_gap();
		// extremes at both ends, then lookups
		send(FN_PUSH_HEAD, 32'sh80000000); maybe_gap();
		send(FN_PEEK_HEAD, 32'sd0);     maybe_gap();
		send(FN_PEEK_TAIL, 32'sd0);     maybe_gap();
		send(FN_PUSH_TAIL, -32'sd1);    maybe_gap();
		send(FN_PUSH_HEAD, 32'sd0);     maybe_gap();
		send(FN_CONTAINS, -32'sd1);     maybe_gap();
		send(FN_CONTAINS, 32'sd5);      maybe_gap();
		// remove of an absent value, then from the middle
		send(FN_REMOVE, 32'sd5);        maybe_gap();
		send(FN_REMOVE, 32'sh80000000); maybe_gap();
		send(FN_PEEK_TAIL, 32'sd0);     maybe_gap();
		send(FN_POP_HEAD, 32'sd0);      maybe_gap();
		send(FN_POP_TAIL, 32'sd0);      maybe_gap();
		// duplicates: remove takes the one nearest the head
		send(FN_PUSH_HEAD, 32'sh55555555); maybe_gap();
		send(FN_PUSH_TAIL, 32'shaaaaaaaa); maybe_gap();
		send(FN_PUSH_TAIL, 32'sh55555555); maybe_gap();
		send(FN_REMOVE, 32'sh55555555); maybe_gap();
		send(FN_CONTAINS, 32'sh55555555); maybe_gap();

		// random segments; the first one fills the queue past full
		mix = MIX_FILL;
		seg_len = 120;
		while (sent < ITEMS) begin
			for (k = 0; k < seg_len && sent < ITEMS; k++) begin
				if (sent >= CALM_FROM) calm = 1'b1;
				maybe_gap();
				send(pick_func(mix), pick_value());
			end
			mix = mix_t'($urandom_range(0, 2));
			seg_len = $urandom_range(40, 110);
		end
		req_valid <= 1'b0;

		// drain outstanding results, then allow for any stray response
		while (awaited != 0) @(negedge clk);
		repeat (16) @(posedge clk);

		$display("%0d requests sent, %0d responses checked", sent, checked);
		$display("%0d pushes on a full queue, %0d pops/peeks on empty, %0d search hits",
			full_hits, empty_hits, found_hits);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// hang guard
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
